>>> hdl/artc_pkg.sv
// Shared types, constants and helpers of the association-rule transaction classifier.
`timescale 1ns / 1ps
package artc_pkg;

    localparam int ITEM_SLOTS_DEF = 32;
    localparam int SLOT_W         = 5;
    localparam int MASK_W         = 32;
    localparam int CNT_W          = 32;
    localparam int CLASS_W        = 3;
    localparam int CFG_AW         = 3;
    localparam int CFG_DW         = 32;
    localparam int QUEUE_DEPTH    = 2;
    localparam int QUEUE_AW       = $clog2(QUEUE_DEPTH);

    // Register index, taken from paddr[2].
    localparam logic REG_LEFT_MASK  = 1'b0;
    localparam logic REG_RIGHT_MASK = 1'b1;

    typedef enum logic [CLASS_W-1:0] {
        CLS_FULL_FULL  = 3'd0,
        CLS_FULL_PART  = 3'd1,
        CLS_FULL_NONE  = 3'd2,
        CLS_PART_FULL  = 3'd3,
        CLS_PART_PART  = 3'd4,
        CLS_PART_NONE  = 3'd5,
        CLS_UNRECORDED = 3'd6
    } t_class;

    typedef struct packed {
        logic   valid;
        t_class cls;
    } t_q_entry;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (&v) ? v : v + CNT_W'(1);
    endfunction

endpackage

>>> hdl/artc_if.sv
// Item and result channel interfaces of the transaction classifier.
`timescale 1ns / 1ps
interface artc_in_if
    import artc_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [SLOT_W-1:0] item_slot;
    logic              item_present;
    logic              last_item;

    modport source(output valid, item_slot, item_present, last_item, input ready);
    modport sink(input valid, item_slot, item_present, last_item, output ready);
endinterface

interface artc_out_if
    import artc_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [CLASS_W-1:0] cluster_class;
    logic [CNT_W-1:0]   transaction_total;
    logic [CNT_W-1:0]   both_full_total;
    logic [CNT_W-1:0]   left_full_total;
    logic [CNT_W-1:0]   violating_total;

    modport source(output valid, cluster_class, transaction_total, both_full_total,
                   left_full_total, violating_total, input ready);
    modport sink(input valid, cluster_class, transaction_total, both_full_total,
                 left_full_total, violating_total, output ready);
endinterface

>>> hdl/artc_front.sv
// Front end: collects the seen map of a transaction and classifies it at its last item.
`timescale 1ns / 1ps
module artc_front
    import artc_pkg::*;
#(
    parameter int ITEM_SLOTS = ITEM_SLOTS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    artc_in_if.sink           i_item,
    input  logic [MASK_W-1:0] i_left_mask,
    input  logic [MASK_W-1:0] i_right_mask,
    input  logic              i_q_full,
    output logic              o_push,
    output t_class            o_class
);

    // Slots are at most 5 bits wide, so only the low 32 slots can ever be seen.
    localparam int SEEN_W = (ITEM_SLOTS < MASK_W) ? ITEM_SLOTS : MASK_W;

    logic [SEEN_W-1:0] r_seen;
    logic [SEEN_W-1:0] n_seen;
    logic [SEEN_W-1:0] seen_now;
    logic [SEEN_W-1:0] lm;
    logic [SEEN_W-1:0] rm;
    logic              slot_ok;
    logic              accept;
    logic              nonempty;
    logic              lfull;
    logic              lpres;
    logic              rfull;
    logic              rpres;

    assign i_item.ready = !i_q_full;
    assign accept       = i_item.valid && i_item.ready;
    assign slot_ok      = int'(i_item.item_slot) < ITEM_SLOTS;

    assign seen_now = (i_item.item_present && slot_ok)
                      ? (r_seen | (SEEN_W'(1) << i_item.item_slot)) : r_seen;

    assign lm       = i_left_mask[SEEN_W-1:0];
    assign rm       = i_right_mask[SEEN_W-1:0];
    assign nonempty = |seen_now;
    assign lfull    = nonempty && ((lm & ~seen_now) == '0);
    assign lpres    = nonempty && ((lm == '0) || ((lm & seen_now) != '0));
    assign rfull    = nonempty && ((rm & ~seen_now) == '0);
    assign rpres    = nonempty && ((rm == '0) || ((rm & seen_now) != '0));

    always_comb begin
        if (!lpres) begin
            o_class = CLS_UNRECORDED;
        end else if (lfull) begin
            o_class = !rpres ? CLS_FULL_NONE : (rfull ? CLS_FULL_FULL : CLS_FULL_PART);
        end else begin
            o_class = !rpres ? CLS_PART_NONE : (rfull ? CLS_PART_FULL : CLS_PART_PART);
        end
    end

    assign o_push = accept && i_item.last_item;

    // Clear the map once the transaction ends.
    always_comb begin
        n_seen = r_seen;
        if (accept) begin
            n_seen = i_item.last_item ? '0 : seen_now;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= '0;
        end else begin
            r_seen <= n_seen;
        end
    end

endmodule

>>> hdl/artc_queue.sv
// Short class queue between front and back ends.
`timescale 1ns / 1ps
module artc_queue
    import artc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_class   i_class,
    input  logic     i_pop,
    output logic     o_full,
    output t_q_entry o_head
);

    t_class              r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr;
    logic [QUEUE_AW:0]   r_count;

    assign o_full       = r_count == (QUEUE_AW+1)'(QUEUE_DEPTH);
    assign o_head.valid = r_count != '0;
    assign o_head.cls   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_class;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0
                                                                     : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0
                                                                     : r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

>>> hdl/artc_back.sv
// Back end: updates the saturating counters and holds the result register.
`timescale 1ns / 1ps
module artc_back
    import artc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_q_entry i_head,
    output logic     o_pop,
    artc_out_if.source o_result
);

    logic             r_valid;
    t_class           r_class;
    logic [CNT_W-1:0] r_cnt_all;
    logic [CNT_W-1:0] r_cnt_both;
    logic [CNT_W-1:0] r_cnt_left;
    logic [CNT_W-1:0] r_cnt_viol;
    logic             recorded;
    logic             left_full;

    // Take the next class when the result register is empty or being drained.
    assign o_pop = i_head.valid && (!r_valid || o_result.ready);

    assign recorded  = i_head.cls != CLS_UNRECORDED;
    assign left_full = (i_head.cls == CLS_FULL_FULL) || (i_head.cls == CLS_FULL_PART)
                       || (i_head.cls == CLS_FULL_NONE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= 1'b0;
            r_cnt_all  <= '0;
            r_cnt_both <= '0;
            r_cnt_left <= '0;
            r_cnt_viol <= '0;
        end else begin
            if (o_pop) begin
                r_valid   <= 1'b1;
                r_cnt_all <= sat_inc(r_cnt_all);
                if (left_full) begin
                    r_cnt_left <= sat_inc(r_cnt_left);
                end
                if (i_head.cls == CLS_FULL_FULL) begin
                    r_cnt_both <= sat_inc(r_cnt_both);
                end
                if (recorded && (i_head.cls != CLS_FULL_FULL)) begin
                    r_cnt_viol <= sat_inc(r_cnt_viol);
                end
            end else if (o_result.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_class <= i_head.cls;
        end
    end

    // Counters move only on a pop, so they stay put while a result waits.
    assign o_result.valid             = r_valid;
    assign o_result.cluster_class     = r_class;
    assign o_result.transaction_total = r_cnt_all;
    assign o_result.both_full_total   = r_cnt_both;
    assign o_result.left_full_total   = r_cnt_left;
    assign o_result.violating_total   = r_cnt_viol;

endmodule

>>> hdl/assoc_rule_transaction_classifier.sv
// Top level of the association-rule transaction classifier.
//
// Items enter on i_item (valid/ready): item_slot, item_present, last_item.
// Each present item sets its slot bit in a seen map; the item with last_item
// closes the transaction, which is classified against left_mask and
// right_mask into one of six cluster classes or unrecorded. Only a last item
// yields a result on o_result: the class plus four saturating counters
// (all, both full, left full, violating), reported after the update.
// Masks are written through the APB port (left_mask at 0x0, right_mask at
// 0x4) by the user only while the block is idle; the block does not enforce
// this. pready is always high. Throughput: one item per cycle while the class
// queue has room. A last item's class goes through a class queue entry into
// the result register, where its result is shown. The front accepts items
// while the two-entry class queue has room, so a stalled receiver holds the
// result register, fills the queue and then drops i_item.ready, which holds
// every item, final or not, until the result register drains.
// Synchronous reset clears the seen map, the counters, the masks and the
// queue; the block takes items in the first cycle after reset.
`timescale 1ns / 1ps
module assoc_rule_transaction_classifier
    import artc_pkg::*;
#(
    parameter int ITEM_SLOTS = ITEM_SLOTS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    artc_in_if.sink           i_item,
    artc_out_if.source        o_result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [CFG_DW-1:0] pwdata,
    output logic [CFG_DW-1:0] prdata,
    output logic              pready
);

    logic [MASK_W-1:0] r_left_mask;
    logic [MASK_W-1:0] r_right_mask;
    logic              cfg_wr;
    logic              reg_idx;
    logic              q_full;
    logic              push;
    logic              pop;
    t_class            push_class;
    t_q_entry          q_head;

    assign pready  = 1'b1;
    assign reg_idx = paddr[2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_mask  <= '0;
            r_right_mask <= '0;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_LEFT_MASK:  r_left_mask  <= pwdata;
                REG_RIGHT_MASK: r_right_mask <= pwdata;
                default:        r_left_mask  <= r_left_mask;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_LEFT_MASK:  prdata = r_left_mask;
            REG_RIGHT_MASK: prdata = r_right_mask;
            default:        prdata = '0;
        endcase
    end

    artc_front #(
        .ITEM_SLOTS(ITEM_SLOTS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_item),
        .i_left_mask (r_left_mask),
        .i_right_mask(r_right_mask),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_class     (push_class)
    );

    artc_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_class(push_class),
        .i_pop  (pop),
        .o_full (q_full),
        .o_head (q_head)
    );

    artc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (q_head),
        .o_pop   (pop),
        .o_result(o_result)
    );

endmodule

>>> hdl/artc_checker.sv
// Port-level checks of the transaction classifier, bound to the top level.
`timescale 1ns / 1ps
module artc_checker
    import artc_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               i_ready,
    input logic [CLASS_W-1:0] i_class,
    input logic [CNT_W-1:0]   i_total,
    input logic [CNT_W-1:0]   i_both,
    input logic [CNT_W-1:0]   i_left,
    input logic [CNT_W-1:0]   i_viol
);

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_class) && $stable(i_total))
        else $error("stalled result changed");

    a_both_le_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> i_both <= i_left)
        else $error("both-full count exceeds left-full count");

    a_counts_le_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> (i_left <= i_total) && (i_viol <= i_total))
        else $error("class count exceeds transaction count");

    a_full_full_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_class == CLS_FULL_FULL) |-> i_both != '0)
        else $error("full/full class without both-full count");

endmodule

bind assoc_rule_transaction_classifier artc_checker u_artc_checker (
    .i_clk  (i_clk),
    .i_rst_n(i_rst_n),
    .i_valid(o_result.valid),
    .i_ready(o_result.ready),
    .i_class(o_result.cluster_class),
    .i_total(o_result.transaction_total),
    .i_both (o_result.both_full_total),
    .i_left (o_result.left_full_total),
    .i_viol (o_result.violating_total)
);
